### hw/rtl/crcse_pkg.sv
// Shared constants, types and CRC-32C matrix functions for the CRC-32C stream engine.
package crcse_pkg;

   // Item geometry
   localparam int unsigned BYTES_PER_ITEM = 8;
   localparam int unsigned BYTE_W         = 8;
   localparam int unsigned DATA_W         = BYTES_PER_ITEM * BYTE_W;
   localparam int unsigned COUNT_W        = 4;
   localparam int unsigned SHIFT_W        = $clog2(DATA_W + 1);
   localparam int unsigned CRC_W          = 32;

   // Reflected Castagnoli polynomial and register init
   localparam logic [CRC_W-1:0] CRC_POLY = 32'h82F63B78;
   localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFFFFFF;

   typedef logic [CRC_W-1:0] crc_type;

   // Item control carried from the lane stage into the merge stage
   typedef struct packed {
      logic               first;
      logic               last;
      logic [COUNT_W-1:0] count;
      crc_type            start;
   } ctrl_type;

   // Column of the zero-byte advance matrix: unit vector bit_idx pushed through
   // nbytes byte steps. Only ever called with constant arguments.
   function automatic crc_type adv_column(int unsigned nbytes, int unsigned bit_idx);
      crc_type v;
      v = crc_type'(1) << bit_idx;
      for (int unsigned s = 0; s < nbytes * BYTE_W; s++) begin
         v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
      end
      return v;
   endfunction

   // Advance a remainder by nbytes zero bytes: GF(2) matrix times vector (XOR tree)
   function automatic crc_type advance(crc_type v, int unsigned nbytes);
      crc_type acc;
      acc = '0;
      for (int unsigned i = 0; i < CRC_W; i++) begin
         if (v[i]) begin
            acc = acc ^ adv_column(nbytes, i);
         end
      end
      return acc;
   endfunction

   // Classic 256-entry byte table: one byte step from a zero remainder
   function automatic crc_type byte_table(logic [BYTE_W-1:0] b);
      return advance(crc_type'(b), 1);
   endfunction

endpackage

### hw/rtl/crcse_lane.sv
// One byte lane: table lookup of its byte, registered for the merge stage.
module crcse_lane (
   input  logic                          clock,
   input  logic                          load,
   input  logic [crcse_pkg::BYTE_W-1:0]  byte_in,
   output crcse_pkg::crc_type            term_ff
);
   import crcse_pkg::*;

   crc_type term_in;

   // byte table lookup
   always_comb begin
      term_in = byte_table(byte_in);
   end

   // payload register, held while the item is stalled
   always_ff @(posedge clock) begin
      if (load) begin
         term_ff <= term_in;
      end
   end

endmodule

### hw/rtl/crcse_merge.sv
// Merge stage: folds lane terms into the running remainder and produces the CRC.
module crcse_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  crcse_pkg::ctrl_type   ctrl,
   input  crcse_pkg::crc_type    lane_terms [crcse_pkg::BYTES_PER_ITEM],
   output crcse_pkg::crc_type    crc_value
);
   import crcse_pkg::*;

   crc_type remainder_ff;
   crc_type remainder_in;
   crc_type data_crc;
   crc_type seed;
   crc_type seed_adv;
   crc_type crc_next;

   // data part: lane j still has (lanes-1-j) byte steps to go
   always_comb begin
      data_crc = '0;
      for (int unsigned j = 0; j < BYTES_PER_ITEM; j++) begin
         data_crc = data_crc ^ advance(lane_terms[j], BYTES_PER_ITEM - 1 - j);
      end
   end

   // remainder part: seed advanced by the item's byte count
   always_comb begin
      seed     = ctrl.first ? ~ctrl.start : remainder_ff;
      seed_adv = seed;
      for (int unsigned k = 1; k <= BYTES_PER_ITEM; k++) begin
         if (ctrl.count == COUNT_W'(k)) begin
            seed_adv = advance(seed, k);
         end
      end
      crc_next     = seed_adv ^ data_crc;
      remainder_in = ctrl.last ? CRC_INIT : crc_next;
      crc_value    = ~crc_next;
   end

   // running remainder
   always_ff @(posedge clock) begin
      if (reset) begin
         remainder_ff <= CRC_INIT;
      end else if (go) begin
         remainder_ff <= remainder_in;
      end
   end

endmodule

### hw/rtl/crc32c_stream_engine.sv
// Top level of the CRC-32C stream engine: input alignment, lanes, merge and result register.
// Reflected CRC-32C (polynomial 0x82F63B78) over items of up to eight bytes, byte zero in the
// low bits. The engine takes one item every clock cycle while req_stall is low; a result is
// written to the output register after its last item has passed the lane registers. The
// rate is set by the remainder feedback in the merge stage, which folds one whole item into
// the remainder each cycle the lane stage moves on, through a 32-bit XOR matrix. Counts above
// eight are treated as eight, count zero takes no bytes, bytes above the count are ignored.
// While a result waits on rsp_stall, only an item that ends a message waits in the lane stage.
module crc32c_stream_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [crcse_pkg::DATA_W-1:0]  req_data_bytes,
   input  logic [crcse_pkg::COUNT_W-1:0] req_byte_count,
   input  logic                          req_first_item,
   input  logic                          req_last_item,
   input  logic [crcse_pkg::CRC_W-1:0]   req_start_crc,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [crcse_pkg::CRC_W-1:0]   rsp_crc_value
);
   import crcse_pkg::*;

   logic               s1_vld_ff;
   logic               s1_vld_in;
   ctrl_type           ctrl_ff;
   ctrl_type           ctrl_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   crc_type            rsp_crc_ff;
   logic               out_free;
   logic               s1_go;
   logic               s1_load;
   logic               accept;
   logic [COUNT_W-1:0] count_sat;
   logic [SHIFT_W-1:0] align_shift;
   logic [DATA_W-1:0]  aligned;
   crc_type            lane_terms [BYTES_PER_ITEM];
   crc_type            crc_value;

   // handshake: lane stage moves on unless a finished CRC cannot be placed
   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      s1_go     = s1_vld_ff && (!ctrl_ff.last || out_free);
      s1_load   = !s1_vld_ff || s1_go;
      req_stall = !s1_load;
      accept    = req_valid && s1_load;
   end

   // saturate the count and push valid bytes to the top; leading zeros leave a zero CRC alone
   always_comb begin
      count_sat   = (req_byte_count > COUNT_W'(BYTES_PER_ITEM)) ?
                    COUNT_W'(BYTES_PER_ITEM) : req_byte_count;
      align_shift = SHIFT_W'(BYTE_W) *
                    (SHIFT_W'(BYTES_PER_ITEM) - SHIFT_W'(count_sat));
      aligned     = req_data_bytes << align_shift;
      ctrl_in.first = req_first_item;
      ctrl_in.last  = req_last_item;
      ctrl_in.count = count_sat;
      ctrl_in.start = req_start_crc;
   end

   // byte lanes
   for (genvar j = 0; j < BYTES_PER_ITEM; j++) begin : g_lane
      crcse_lane u_lane (
         .clock   (clock),
         .load    (accept),
         .byte_in (aligned[j*BYTE_W +: BYTE_W]),
         .term_ff (lane_terms[j])
      );
   end

   // lane stage control
   always_comb begin
      s1_vld_in = s1_load ? req_valid : s1_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ctrl_ff <= ctrl_in;
      end
   end

   // merge and remainder
   crcse_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .go         (s1_go),
      .ctrl       (ctrl_ff),
      .lane_terms (lane_terms),
      .crc_value  (crc_value)
   );

   // result register
   always_comb begin
      if (s1_go && ctrl_ff.last) begin
         rsp_valid_in = 1'b1;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && ctrl_ff.last) begin
         rsp_crc_ff <= crc_value;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_crc_value = rsp_crc_ff;

endmodule
